// ===== sv/lpcp_pkg.sv =====
`timescale 1ns / 1ps
// Package for the lidar point to camera pixel projection block.
// Holds the fixed camera constants, register indexes and status codes; no dependencies.
package lpcp_pkg;

    localparam int POINT_W = 32;
    localparam int INTEN_W = 16;
    localparam int DIM_W = 13;
    localparam int STATUS_W = 2;
    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W = 32;

    // Register indexes on the configuration port.
    localparam logic [CFG_INDEX_W-1:0] CFG_X_MIN = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_X_MAX = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_Y_MIN = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_Y_MAX = 8'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_INTEN_MIN = 8'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_WIDTH = 8'd5;
    localparam logic [CFG_INDEX_W-1:0] CFG_HEIGHT = 8'd6;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STATUS_REJECTED = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_OUTSIDE = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_ON_IMAGE = 2'd2;

    // Translation magnitudes in Q.32, rounded later to the point format.
    localparam logic [63:0] TX_Q32 = 64'd214748365;
    localparam logic [63:0] TY_Q32 = 64'd429496730;
    localparam logic [63:0] TZ_Q32 = 64'd1975684956;

    // Intrinsics in Q.16.
    localparam int INTR_W = 26;
    localparam logic signed [INTR_W-1:0] FX_Q16 = 26'sd21830046;
    localparam logic signed [INTR_W-1:0] PPX_Q16 = 26'sd21672197;
    localparam logic signed [INTR_W-1:0] FY_Q16 = 26'sd22007314;
    localparam logic signed [INTR_W-1:0] PPY_Q16 = 26'sd16758755;

    // Camera frame coordinates, products and numerators.
    localparam int CAM_W = 34;
    localparam int PROD_W = INTR_W + CAM_W;
    localparam int NUM_W = 62;
    localparam int DEN_W = CAM_W + 16;

endpackage

// ===== sv/lidar_point_camera_projection.sv =====
`timescale 1ns / 1ps
// Top level of the lidar point to camera pixel projection pipeline.
// Depends on lpcp_pkg for constants and status codes.
//
// Channel   Direction  Handshake           Payload
// in        input      in_valid/in_stall   point_x, point_y, point_z, intensity
// out       output     out_valid/out_stall status, pixel_u, pixel_v
// cfg       input      cfg_valid/cfg_ready cfg_index, cfg_data
//
// One point enters per cycle while in_stall is low.
// The restoring divider produces one quotient bit per stage for u and v.
// Reset empties the pipeline and loads the register defaults; configuration is always ready.
// A stalled output holds; each stage moves when the stage after it is empty or moving,
// so bubbles close up and nothing is dropped or repeated.
module lidar_point_camera_projection
    import lpcp_pkg::*;
#(
    parameter int PIXEL_COORD_BITS = 12,
    parameter int POINT_FRAC_BITS = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic signed [POINT_W-1:0]   point_x,
    input  logic signed [POINT_W-1:0]   point_y,
    input  logic signed [POINT_W-1:0]   point_z,
    input  logic [INTEN_W-1:0]          intensity,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [STATUS_W-1:0]         status,
    output logic [PIXEL_COORD_BITS-1:0] pixel_u,
    output logic [PIXEL_COORD_BITS-1:0] pixel_v,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [CFG_INDEX_W-1:0]      cfg_index,
    input  logic [CFG_DATA_W-1:0]       cfg_data
);

    localparam int P = PIXEL_COORD_BITS;
    localparam int DW = ((NUM_W > DEN_W + P) ? NUM_W : DEN_W + P) + 1;
    localparam int CMP_W = ((P > DIM_W) ? P : DIM_W) + 1;
    localparam int NSTG = P + 6;
    localparam int DIV0 = 4;

    localparam logic [63:0] TX_F64 =
        (TX_Q32 + (64'd1 << (31 - POINT_FRAC_BITS))) >> (32 - POINT_FRAC_BITS);
    localparam logic [63:0] TY_F64 =
        (TY_Q32 + (64'd1 << (31 - POINT_FRAC_BITS))) >> (32 - POINT_FRAC_BITS);
    localparam logic [63:0] TZ_F64 =
        (TZ_Q32 + (64'd1 << (31 - POINT_FRAC_BITS))) >> (32 - POINT_FRAC_BITS);
    localparam logic signed [CAM_W-1:0] TX_F = CAM_W'(TX_F64);
    localparam logic signed [CAM_W-1:0] TY_F = CAM_W'(TY_F64);
    localparam logic signed [CAM_W-1:0] TZ_F = CAM_W'(TZ_F64);

    typedef struct packed {
        logic                   pass;
        logic                   zero;
        logic                   neg_u;
        logic                   neg_v;
        logic                   ovf_u;
        logic                   ovf_v;
        logic [DEN_W-1:0]       den;
        logic [DW-1:0]          rem_u;
        logic [DW-1:0]          rem_v;
        logic [P-1:0]           quo_u;
        logic [P-1:0]           quo_v;
    } div_t;

    // Configuration registers.
    logic signed [POINT_W-1:0] x_min_reg, x_max_reg, y_min_reg, y_max_reg;
    logic [INTEN_W-1:0]        inten_min_reg;
    logic [DIM_W-1:0]          width_reg, height_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_min_reg     <= 32'sd0;
            x_max_reg     <= 32'sd98304;
            y_min_reg     <= -32'sd32768;
            y_max_reg     <= 32'sd32768;
            inten_min_reg <= 16'd512;
            width_reg     <= 13'd640;
            height_reg    <= 13'd480;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_X_MIN:     x_min_reg <= cfg_data;
                CFG_X_MAX:     x_max_reg <= cfg_data;
                CFG_Y_MIN:     y_min_reg <= cfg_data;
                CFG_Y_MAX:     y_max_reg <= cfg_data;
                CFG_INTEN_MIN: inten_min_reg <= cfg_data[INTEN_W-1:0];
                CFG_WIDTH:     width_reg <= cfg_data[DIM_W-1:0];
                CFG_HEIGHT:    height_reg <= cfg_data[DIM_W-1:0];
                default:       ;
            endcase
        end
    end

    // Stage enables: a stage loads when it is empty or its contents move on.
    logic [NSTG-1:0] valid_reg;
    logic [NSTG-1:0] en;

    always_comb
    begin
        en[NSTG-1] = !valid_reg[NSTG-1] || !out_stall;
        for (int i = NSTG - 2; i >= 0; i--)
        begin
            en[i] = !valid_reg[i] || en[i+1];
        end
    end

    assign in_stall = !en[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                valid_reg[0] <= in_valid;
            end
            for (int i = 1; i < NSTG; i++)
            begin
                if (en[i])
                begin
                    valid_reg[i] <= valid_reg[i-1];
                end
            end
        end
    end

    // Stage 0: window test and extrinsic transform.
    logic                    s0_pass_next, s0_pass_reg;
    logic signed [CAM_W-1:0] s0_cx_next, s0_cy_next, s0_cz_next;
    logic signed [CAM_W-1:0] s0_cx_reg, s0_cy_reg, s0_cz_reg;

    always_comb
    begin
        s0_pass_next = (point_x >= x_min_reg) && (point_x <= x_max_reg) &&
                       (point_y >= y_min_reg) && (point_y <= y_max_reg) &&
                       (intensity >= inten_min_reg);
        s0_cx_next = TX_F - CAM_W'(point_y);
        s0_cy_next = CAM_W'(point_y) - CAM_W'(point_z) + TY_F;
        s0_cz_next = CAM_W'(point_x) - TZ_F;
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            s0_pass_reg <= s0_pass_next;
            s0_cx_reg   <= s0_cx_next;
            s0_cy_reg   <= s0_cy_next;
            s0_cz_reg   <= s0_cz_next;
        end
    end

    // Stage 1: the four intrinsic products.
    logic                     s1_pass_reg, s1_zero_reg, s1_czneg_reg;
    logic signed [CAM_W-1:0]  s1_cz_reg;
    logic signed [PROD_W-1:0] s1_fx_reg, s1_ppx_reg, s1_fy_reg, s1_ppy_reg;

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            s1_pass_reg  <= s0_pass_reg;
            s1_zero_reg  <= (s0_cz_reg == '0);
            s1_czneg_reg <= s0_cz_reg[CAM_W-1];
            s1_cz_reg    <= s0_cz_reg;
            s1_fx_reg    <= FX_Q16 * s0_cx_reg;
            s1_ppx_reg   <= PPX_Q16 * s0_cz_reg;
            s1_fy_reg    <= FY_Q16 * s0_cy_reg;
            s1_ppy_reg   <= PPY_Q16 * s0_cz_reg;
        end
    end

    // Stage 2: numerators and divisor magnitude.
    logic                    s2_pass_reg, s2_zero_reg, s2_czneg_reg;
    logic signed [NUM_W-1:0] s2_nu_reg, s2_nv_reg;
    logic [DEN_W-1:0]        s2_den_reg;
    logic [CAM_W-1:0]        s1_cz_abs;

    assign s1_cz_abs = s1_czneg_reg ? CAM_W'(-s1_cz_reg) : CAM_W'(s1_cz_reg);

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            s2_pass_reg  <= s1_pass_reg;
            s2_zero_reg  <= s1_zero_reg;
            s2_czneg_reg <= s1_czneg_reg;
            s2_nu_reg    <= NUM_W'(s1_fx_reg) + NUM_W'(s1_ppx_reg);
            s2_nv_reg    <= NUM_W'(s1_fy_reg) + NUM_W'(s1_ppy_reg);
            s2_den_reg   <= {s1_cz_abs, 16'd0};
        end
    end

    // Stage 3: numerator magnitudes and quotient signs.
    logic             s3_pass_reg, s3_zero_reg, s3_negu_reg, s3_negv_reg;
    logic [NUM_W-1:0] s3_au_reg, s3_av_reg;
    logic [DEN_W-1:0] s3_den_reg;

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            s3_pass_reg <= s2_pass_reg;
            s3_zero_reg <= s2_zero_reg;
            s3_negu_reg <= s2_nu_reg[NUM_W-1] ^ s2_czneg_reg;
            s3_negv_reg <= s2_nv_reg[NUM_W-1] ^ s2_czneg_reg;
            s3_au_reg   <= s2_nu_reg[NUM_W-1] ? NUM_W'(-s2_nu_reg) : NUM_W'(s2_nu_reg);
            s3_av_reg   <= s2_nv_reg[NUM_W-1] ? NUM_W'(-s2_nv_reg) : NUM_W'(s2_nv_reg);
            s3_den_reg  <= s2_den_reg;
        end
    end

    // Divider entry: a quotient of 2^P or more lies off any image.
    div_t div_reg [0:P];
    logic [DW-1:0] den_top;

    assign den_top = DW'(s3_den_reg) << P;

    always_ff @(posedge clk)
    begin
        if (en[DIV0])
        begin
            div_reg[0].pass  <= s3_pass_reg;
            div_reg[0].zero  <= s3_zero_reg;
            div_reg[0].neg_u <= s3_negu_reg;
            div_reg[0].neg_v <= s3_negv_reg;
            div_reg[0].ovf_u <= DW'(s3_au_reg) >= den_top;
            div_reg[0].ovf_v <= DW'(s3_av_reg) >= den_top;
            div_reg[0].den   <= s3_den_reg;
            div_reg[0].rem_u <= DW'(s3_au_reg);
            div_reg[0].rem_v <= DW'(s3_av_reg);
            div_reg[0].quo_u <= '0;
            div_reg[0].quo_v <= '0;
        end
    end

    // Restoring division, one quotient bit per stage, most significant first.
    for (genvar k = 0; k < P; k++)
    begin : g_div
        logic [DW-1:0] trial_den;
        logic          take_u, take_v;
        div_t          step_next;

        assign trial_den = DW'(div_reg[k].den) << (P - 1 - k);
        assign take_u = div_reg[k].rem_u >= trial_den;
        assign take_v = div_reg[k].rem_v >= trial_den;

        always_comb
        begin
            step_next = div_reg[k];
            step_next.rem_u = take_u ? div_reg[k].rem_u - trial_den : div_reg[k].rem_u;
            step_next.rem_v = take_v ? div_reg[k].rem_v - trial_den : div_reg[k].rem_v;
            step_next.quo_u = {div_reg[k].quo_u[P-2:0], take_u};
            step_next.quo_v = {div_reg[k].quo_v[P-2:0], take_v};
        end

        always_ff @(posedge clk)
        begin
            if (en[DIV0+1+k])
            begin
                div_reg[k+1] <= step_next;
            end
        end
    end

    // Output stage: range check against the image size.
    div_t                  fin;
    logic                  off_image;
    logic [STATUS_W-1:0]   status_next, status_reg;
    logic [P-1:0]          pix_u_next, pix_v_next, pix_u_reg, pix_v_reg;

    assign fin = div_reg[P];

    always_comb
    begin
        off_image = fin.zero || fin.ovf_u || fin.ovf_v ||
                    (fin.neg_u && (fin.quo_u != '0)) ||
                    (fin.neg_v && (fin.quo_v != '0)) ||
                    (CMP_W'(fin.quo_u) >= CMP_W'(width_reg)) ||
                    (CMP_W'(fin.quo_v) >= CMP_W'(height_reg));
        pix_u_next = '0;
        pix_v_next = '0;
        if (!fin.pass)
        begin
            status_next = STATUS_REJECTED;
        end
        else if (off_image)
        begin
            status_next = STATUS_OUTSIDE;
        end
        else
        begin
            status_next = STATUS_ON_IMAGE;
            pix_u_next  = fin.quo_u;
            pix_v_next  = fin.quo_v;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[NSTG-1])
        begin
            status_reg <= status_next;
            pix_u_reg  <= pix_u_next;
            pix_v_reg  <= pix_v_next;
        end
    end

    assign out_valid = valid_reg[NSTG-1];
    assign status    = status_reg;
    assign pixel_u   = pix_u_reg;
    assign pixel_v   = pix_v_reg;

endmodule

// ===== sv/lpcp_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for the projection pipeline, bound to the top level.
// Depends on lpcp_pkg for status codes and port widths.
module lpcp_checker
    import lpcp_pkg::*;
#(
    parameter int PIXEL_COORD_BITS = 12
) (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_stall,
    input logic                        out_valid,
    input logic                        out_stall,
    input logic [STATUS_W-1:0]         status,
    input logic [PIXEL_COORD_BITS-1:0] pixel_u,
    input logic [PIXEL_COORD_BITS-1:0] pixel_v
);

    // Pixels are only reported for points that land on the image.
    a_pixel_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != STATUS_ON_IMAGE) |-> (pixel_u == '0) && (pixel_v == '0))
        else $error("pixel nonzero without on-image status");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status == STATUS_REJECTED) || (status == STATUS_OUTSIDE) ||
                      (status == STATUS_ON_IMAGE))
        else $error("undefined status code");

    // A held result keeps its payload.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status) && $stable(pixel_u) &&
                                   $stable(pixel_v))
        else $error("stalled result changed");

    // The pipeline only pushes back on its input when its output is blocked.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled while output is free");

endmodule

bind lidar_point_camera_projection lpcp_checker #(
    .PIXEL_COORD_BITS(PIXEL_COORD_BITS)
) u_lpcp_checker (
    .clk(clk),
    .rst_n(rst_n),
    .in_stall(in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .status(status),
    .pixel_u(pixel_u),
    .pixel_v(pixel_v)
);
